// ===== sv/lcm_pkg.sv =====
// Shared types and constants for the LED channel mix and PWM duty block.
package lcm_pkg;

   localparam int CHAN_W      = 3;
   localparam int LEVEL_W     = 8;
   localparam int PERIOD_W    = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIX_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PWM_PERIOD = 2'd1;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd65535;
   localparam logic [LEVEL_W-1:0]  FULL         = 8'd255;

   // x / 255 by reciprocal: exact for 16-bit and 32-bit dividends
   localparam logic [15:0] DIV255_M16 = 16'h8081;
   localparam int          DIV255_S16 = 23;
   localparam logic [31:0] DIV255_M32 = 32'h8080_8081;
   localparam int          DIV255_S32 = 39;

   typedef enum logic [2:0] {
      MODE_SINGLE = 3'd0,
      MODE_ALL    = 3'd1,
      MODE_COLD   = 3'd2,
      MODE_WARM   = 3'd3,
      MODE_TINT   = 3'd4,
      MODE_SEQ    = 3'd5
   } mix_mode_type;

   localparam mix_mode_type MIX_MODE_RESET = MODE_ALL;

   typedef enum logic [1:0] {
      WK_ZERO,
      WK_FULL,
      WK_VALUE,
      WK_SEQ
   } weight_kind_type;

   typedef struct packed {
      logic [CHAN_W-1:0] ch;
      logic              last;
   } tag_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      tag_type            tag;
   } item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] weight;
      logic               direct;
      tag_type            tag;
   } weight_word_type;

endpackage

// ===== sv/lcm_issue.sv =====
// Channel sequencer: takes a level word and issues one entry per channel.
module lcm_issue import lcm_pkg::*; #(
   parameter int CHANNELS = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [LEVEL_W-1:0] level,
   output logic               busy,
   output logic               out_valid,
   output item_type           out_item
);

   localparam logic [CHAN_W-1:0] LAST_CH = CHAN_W'(CHANNELS - 1);

   logic               busy_ff, busy_in;
   logic [CHAN_W-1:0]  next_ch_ff, next_ch_in;
   logic [LEVEL_W-1:0] hold_ff, hold_in;
   logic               valid_ff, valid_in;
   item_type           item_ff, item_in;
   logic               accept;

   assign accept = start && !busy_ff;

   always_comb begin
      busy_in    = busy_ff;
      next_ch_in = next_ch_ff;
      hold_in    = hold_ff;
      valid_in   = 1'b0;
      item_in    = item_ff;
      if (accept) begin
         valid_in         = 1'b1;
         item_in.level    = level;
         item_in.tag.ch   = '0;
         item_in.tag.last = (CHANNELS == 1);
         hold_in          = level;
         busy_in          = (CHANNELS > 1);
         next_ch_in       = CHAN_W'(1);
      end else if (busy_ff) begin
         valid_in         = 1'b1;
         item_in.level    = hold_ff;
         item_in.tag.ch   = next_ch_ff;
         item_in.tag.last = (next_ch_ff == LAST_CH);
         // drop busy once the final channel goes out
         busy_in          = (next_ch_ff != LAST_CH);
         next_ch_in       = next_ch_ff + CHAN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         next_ch_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         next_ch_ff <= next_ch_in;
         valid_ff   <= valid_in;
      end
      hold_ff <= hold_in;
      item_ff <= item_in;
   end

   assign busy      = busy_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== sv/lcm_weight.sv =====
// Weight pipeline: picks each channel's weight from the mix mode, three stages.
module lcm_weight import lcm_pkg::*; #(
   parameter int CHANNELS = 2
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  item_type        in_item,
   input  mix_mode_type    mode,
   output logic            out_valid,
   output weight_word_type out_word
);

   localparam int SLICE   = 255 / CHANNELS;
   localparam int RECIP_W = 25;
   localparam int PROD_W  = 16 + RECIP_W;
   // ceil(2^24 / SLICE): exact quotient for any 16-bit dividend
   localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(((2 ** 24) + SLICE - 1) / SLICE);
   localparam logic [8:0]         SLICE_9 = 9'(SLICE);

   // stage B: mode decode and ramp numerator
   logic [8:0]         start_pos, stop_pos, level_9;
   logic [LEVEL_W-1:0] diff;
   weight_kind_type    kind;
   logic [LEVEL_W-1:0] value;
   logic               direct;

   logic               b_valid_ff;
   weight_kind_type    b_kind_ff;
   logic [LEVEL_W-1:0] b_value_ff, b_level_ff;
   logic [15:0]        b_prod_ff, b_prod_in;
   logic               b_direct_ff;
   tag_type            b_tag_ff;

   // stage C: reciprocal product
   logic               c_valid_ff;
   weight_kind_type    c_kind_ff;
   logic [LEVEL_W-1:0] c_value_ff, c_level_ff;
   logic [PROD_W-1:0]  c_prod_ff, c_prod_in;
   logic               c_direct_ff;
   tag_type            c_tag_ff;

   // stage D: weight select
   logic               d_valid_ff;
   weight_word_type    d_word_ff, d_word_in;

   always_comb begin
      start_pos = 9'(in_item.tag.ch) * SLICE_9;
      stop_pos  = start_pos + SLICE_9;
      level_9   = {1'b0, in_item.level};
      diff      = in_item.level - start_pos[LEVEL_W-1:0];
      b_prod_in = {diff, 8'd0} - {8'd0, diff};
      value     = '0;
      direct    = (mode == MODE_TINT) && (CHANNELS >= 2);
      case (mode)
         MODE_ALL: kind = WK_FULL;
         MODE_WARM: begin
            if (CHANNELS > 1) kind = (in_item.tag.ch == CHAN_W'(1)) ? WK_FULL : WK_ZERO;
            else kind = (in_item.tag.ch == '0) ? WK_FULL : WK_ZERO;
         end
         MODE_TINT: begin
            if (CHANNELS >= 2) begin
               if (in_item.tag.ch == '0) begin
                  kind  = WK_VALUE;
                  value = in_item.level;
               end else if (in_item.tag.ch == CHAN_W'(1)) begin
                  kind  = WK_VALUE;
                  value = FULL - in_item.level;
               end else begin
                  kind = WK_ZERO;
               end
            end else begin
               kind = (in_item.tag.ch == '0) ? WK_FULL : WK_ZERO;
            end
         end
         MODE_SEQ: begin
            if (level_9 <= start_pos) kind = WK_ZERO;
            else if (level_9 >= stop_pos) kind = WK_FULL;
            else kind = WK_SEQ;
         end
         default: kind = (in_item.tag.ch == '0) ? WK_FULL : WK_ZERO;
      endcase
   end

   assign c_prod_in = PROD_W'(b_prod_ff) * PROD_W'(RECIP);

   always_comb begin
      d_word_in.level  = c_level_ff;
      d_word_in.direct = c_direct_ff;
      d_word_in.tag    = c_tag_ff;
      case (c_kind_ff)
         WK_ZERO:  d_word_in.weight = '0;
         WK_FULL:  d_word_in.weight = FULL;
         WK_VALUE: d_word_in.weight = c_value_ff;
         WK_SEQ:   d_word_in.weight = c_prod_ff[24 +: LEVEL_W];
         default:  d_word_in.weight = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= in_valid;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
      b_kind_ff   <= kind;
      b_value_ff  <= value;
      b_level_ff  <= in_item.level;
      b_prod_ff   <= b_prod_in;
      b_direct_ff <= direct;
      b_tag_ff    <= in_item.tag;
      c_kind_ff   <= b_kind_ff;
      c_value_ff  <= b_value_ff;
      c_level_ff  <= b_level_ff;
      c_prod_ff   <= c_prod_in;
      c_direct_ff <= b_direct_ff;
      c_tag_ff    <= b_tag_ff;
      d_word_ff   <= d_word_in;
   end

   assign out_valid = d_valid_ff;
   assign out_word  = d_word_ff;

endmodule

// ===== sv/lcm_pulse.sv =====
// Pulse pipeline: channel level and pulse width, each divide by 255 by reciprocal.
module lcm_pulse import lcm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  weight_word_type     in_word,
   input  logic [PERIOD_W-1:0] period,
   output logic                out_strobe,
   output logic [CHAN_W-1:0]   out_channel,
   output logic [PERIOD_W-1:0] out_pulse,
   output logic                out_last
);

   // stage E: level times weight
   logic               e_valid_ff;
   logic [15:0]        e_prod_ff, e_prod_in;
   logic [LEVEL_W-1:0] e_weight_ff;
   logic               e_direct_ff;
   tag_type            e_tag_ff;

   // stage F: reciprocal product for the channel level
   logic               f_valid_ff;
   logic [31:0]        f_prod_ff, f_prod_in;
   logic [LEVEL_W-1:0] f_weight_ff;
   logic               f_direct_ff;
   tag_type            f_tag_ff;

   // stage G: period times channel level
   logic               g_valid_ff;
   logic [LEVEL_W-1:0] chan_level;
   logic [31:0]        g_prod_ff, g_prod_in;
   tag_type            g_tag_ff;

   // stage H: reciprocal product for the pulse
   logic               h_valid_ff;
   logic [63:0]        h_prod_ff, h_prod_in;
   tag_type            h_tag_ff;

   // output register
   logic                strobe_ff;
   logic [CHAN_W-1:0]   channel_ff;
   logic [PERIOD_W-1:0] pulse_ff, pulse_in;
   logic                last_ff;

   assign e_prod_in  = 16'(in_word.level) * 16'(in_word.weight);
   assign f_prod_in  = 32'(e_prod_ff) * 32'(DIV255_M16);
   assign chan_level = f_direct_ff ? f_weight_ff : LEVEL_W'(f_prod_ff >> DIV255_S16);
   assign g_prod_in  = 32'(period) * 32'(chan_level);
   assign h_prod_in  = 64'(g_prod_ff) * 64'(DIV255_M32);
   assign pulse_in   = PERIOD_W'(h_prod_ff >> DIV255_S32);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         e_valid_ff <= in_valid;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= g_valid_ff;
         strobe_ff  <= h_valid_ff;
      end
      e_prod_ff   <= e_prod_in;
      e_weight_ff <= in_word.weight;
      e_direct_ff <= in_word.direct;
      e_tag_ff    <= in_word.tag;
      f_prod_ff   <= f_prod_in;
      f_weight_ff <= e_weight_ff;
      f_direct_ff <= e_direct_ff;
      f_tag_ff    <= e_tag_ff;
      g_prod_ff   <= g_prod_in;
      g_tag_ff    <= f_tag_ff;
      h_prod_ff   <= h_prod_in;
      h_tag_ff    <= g_tag_ff;
      pulse_ff    <= pulse_in;
      channel_ff  <= h_tag_ff.ch;
      last_ff     <= h_tag_ff.last;
   end

   assign out_strobe  = strobe_ff;
   assign out_channel = channel_ff;
   assign out_pulse   = pulse_ff;
   assign out_last    = last_ff;

endmodule

// ===== sv/led_channel_mix_pwm_duty.sv =====
// Top level of the LED channel mix and PWM duty block: registers and pipeline.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ----------------------------
//   request   start, busy, req_level                  taken when start && !busy
//   response  rsp_strobe, rsp_channel, rsp_pulse,     one cycle per word, no stall
//             rsp_last
//   config    csr_valid, csr_ready, csr_index,        written when valid && ready
//             csr_data
//
// Each level word yields CHANNELS response words on consecutive cycles; busy stays
// high after accept until the channel sequencer, issuing one channel per cycle,
// has sent the last channel, so a new word is not taken while the previous one is
// still being issued. The first response word reaches the ports through the issue
// register, stages B to H and the output register (eight-stage pipeline plus output
// register). Reset clears the valid bits and the sequencer and sets the registers
// (mix_mode 1, pwm_period 65535). The pipeline never stalls; csr_ready is always high.
module led_channel_mix_pwm_duty import lcm_pkg::*; #(
   parameter int CHANNELS = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [LEVEL_W-1:0]     req_level,
   output logic                   rsp_strobe,
   output logic [CHAN_W-1:0]      rsp_channel,
   output logic [PERIOD_W-1:0]    rsp_pulse,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   mix_mode_type        mix_mode_ff, mix_mode_in;
   logic [PERIOD_W-1:0] pwm_period_ff, pwm_period_in;

   logic            item_valid;
   item_type        item;
   logic            word_valid;
   weight_word_type word;

   assign csr_ready = 1'b1;

   always_comb begin
      mix_mode_in   = mix_mode_ff;
      pwm_period_in = pwm_period_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIX_MODE:   mix_mode_in   = mix_mode_type'(csr_data[2:0]);
            CSR_PWM_PERIOD: pwm_period_in = csr_data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_mode_ff   <= MIX_MODE_RESET;
         pwm_period_ff <= PERIOD_RESET;
      end else begin
         mix_mode_ff   <= mix_mode_in;
         pwm_period_ff <= pwm_period_in;
      end
   end

   lcm_issue #(
      .CHANNELS (CHANNELS)
   ) u_issue (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .level     (req_level),
      .busy      (busy),
      .out_valid (item_valid),
      .out_item  (item)
   );

   lcm_weight #(
      .CHANNELS (CHANNELS)
   ) u_weight (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (item_valid),
      .in_item   (item),
      .mode      (mix_mode_ff),
      .out_valid (word_valid),
      .out_word  (word)
   );

   lcm_pulse u_pulse (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (word_valid),
      .in_word     (word),
      .period      (pwm_period_ff),
      .out_strobe  (rsp_strobe),
      .out_channel (rsp_channel),
      .out_pulse   (rsp_pulse),
      .out_last    (rsp_last)
   );

endmodule
